// ----- hw/rtl/palette_color_allocator_top_assert.svh -----
// assertion macros for the palette color allocator
`ifndef PALETTE_COLOR_ALLOCATOR_TOP_ASSERT_SVH
`define PALETTE_COLOR_ALLOCATOR_TOP_ASSERT_SVH

// consequent checked at the same edge as the antecedent
`define PCA_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked at the edge after the antecedent
`define PCA_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/pca_pkg.sv -----
// shared types and codes for the palette color allocator
package pca_pkg;

   typedef enum logic [1:0] {
      FUNC_ALLOC   = 2'd0,
      FUNC_NEAREST = 2'd1,
      FUNC_EXACT   = 2'd2,
      FUNC_READ    = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STAT_EXISTING = 2'd0,
      STAT_ADDED    = 2'd1,
      STAT_FULL     = 2'd2,
      STAT_NOMATCH  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_READ,
      ST_DONE
   } state_type;

   localparam int unsigned COLOR_W = 24;
   localparam int unsigned INDEX_W = 8;

   typedef struct packed {
      func_type             func;
      logic [COLOR_W-1:0]   color_in;
      logic [INDEX_W-1:0]   index_in;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0]   index_out;
      logic [COLOR_W-1:0]   color_out;
      status_type           status;
   } rsp_type;

endpackage

// ----- hw/rtl/pca_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
module pca_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- hw/rtl/palette_color_allocator_top.sv -----
// palette color allocator top level: sequencer around the palette ram
//
// Keeps an indexed palette of 24-bit rgb entries in one ram of PALETTE_SIZE
// words plus a count of entries in use. One request is worked on at a time.
// A read issues its ram read at acceptance. The READ state then captures the
// entry into the result register, and the DONE state moves it on to rsp_data
// once the output register is free. Allocate, nearest and exact lookups scan
// the palette through the ram read port, one entry per cycle, and the scan
// stops early on an exact hit or a zero distance. On an empty palette the
// answer needs no scan: the result is formed at acceptance and the sequencer
// goes straight to DONE. Allocate appends a new color with a single ram write
// at the end of its scan, or at acceptance on an empty palette. The result
// register lets the next request be accepted while the previous result still
// waits on rsp_stall. A second finished result holds the sequencer, and so
// req_stall, until the register frees up. Entries at or above the count read
// as zero, so the ram needs no clearing pass after reset. fixed_palette_mode
// (csr port, always ready) must only be written while the block is idle.
module palette_color_allocator_top #(
   parameter int unsigned PALETTE_SIZE = 256
) (
   input  logic             clock,
   input  logic             reset,

   input  logic             req_valid,
   output logic             req_stall,
   input  pca_pkg::req_type req_data,

   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pca_pkg::rsp_type rsp_data,

   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_wdata
);

   localparam int unsigned AW = $clog2(PALETTE_SIZE);      // ram address
   localparam int unsigned CW = $clog2(PALETTE_SIZE + 1);  // count, holds size

   // sequencer state
   pca_pkg::state_type state_ff, state_in;

   // request held during the scan
   pca_pkg::func_type  func_ff, func_in;
   logic [23:0]        color_ff, color_in;
   logic               near_ff, near_in;       // nearest-distance search

   // palette fill level
   logic [CW-1:0]      count_ff, count_in;
   logic               mode_ff;

   // scan pipeline: issue address, then compare in the next cycle
   logic [CW-1:0]      issue_ff, issue_in;
   logic               cmp_valid_ff, cmp_valid_in;
   logic [AW-1:0]      cmp_idx_ff, cmp_idx_in;

   // best candidate so far for the nearest search
   logic [AW-1:0]      best_idx_ff, best_idx_in;
   logic [8:0]         best_dist_ff, best_dist_in;
   logic [23:0]        best_color_ff, best_color_in;

   // finished result and output register
   pca_pkg::rsp_type   res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   pca_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   // ram port
   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [23:0]        ram_wdata;
   logic               ram_re;
   logic [AW-1:0]      ram_raddr;
   logic [23:0]        ram_rdata;

   // decode and compare helpers
   logic               req_xfer;
   logic               req_near;
   logic               out_free;
   logic               scan_done;
   logic               cmp_last;
   logic [7:0]         chan_max;
   logic [7:0]         d_r, d_g, d_b;

   assign req_stall = (state_ff != pca_pkg::ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign req_near  = (req_data.func == pca_pkg::FUNC_NEAREST)
                      || (req_data.func == pca_pkg::FUNC_ALLOC && mode_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // max of per-channel absolute differences
   always_comb begin
      d_r  = (color_ff[23:16] > ram_rdata[23:16]) ? color_ff[23:16] - ram_rdata[23:16]
                                                  : ram_rdata[23:16] - color_ff[23:16];
      d_g  = (color_ff[15:8] > ram_rdata[15:8]) ? color_ff[15:8] - ram_rdata[15:8]
                                                : ram_rdata[15:8] - color_ff[15:8];
      d_b  = (color_ff[7:0] > ram_rdata[7:0]) ? color_ff[7:0] - ram_rdata[7:0]
                                              : ram_rdata[7:0] - color_ff[7:0];
      chan_max = (d_g > d_r) ? d_g : d_r;
      if (d_b > chan_max) begin
         chan_max = d_b;
      end
   end

   // entry under compare is the last one in use
   assign cmp_last = ((CW'(cmp_idx_ff) + CW'(1)) == count_ff);

   // datapath and ram control
   always_comb begin
      func_in       = func_ff;
      color_in      = color_ff;
      near_in       = near_ff;
      count_in      = count_ff;
      issue_in      = issue_ff;
      cmp_valid_in  = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      best_idx_in   = best_idx_ff;
      best_dist_in  = best_dist_ff;
      best_color_in = best_color_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      ram_we        = 1'b0;
      ram_waddr     = AW'(count_ff);
      ram_wdata     = color_ff;
      ram_re        = 1'b0;
      ram_raddr     = AW'(issue_ff);
      scan_done     = 1'b0;

      unique case (state_ff)
         pca_pkg::ST_IDLE: begin
            if (req_xfer) begin
               func_in      = req_data.func;
               color_in     = req_data.color_in;
               near_in      = req_near;
               issue_in     = '0;
               best_idx_in  = '0;
               best_dist_in = 9'h100;
               best_color_in = '0;
               if (req_data.func == pca_pkg::FUNC_READ) begin
                  // out-of-range index reads entry 0
                  ram_re     = 1'b1;
                  ram_raddr  = (32'(req_data.index_in) < PALETTE_SIZE)
                               ? AW'(req_data.index_in) : '0;
                  cmp_idx_in = ram_raddr;
               end else if (count_ff == '0) begin
                  // empty palette answers without a scan
                  if (req_near) begin
                     res_in = '{index_out: '0, color_out: '0,
                                status: pca_pkg::STAT_EXISTING};
                  end else if (req_data.func == pca_pkg::FUNC_EXACT) begin
                     res_in = '{index_out: '0, color_out: '0,
                                status: pca_pkg::STAT_NOMATCH};
                  end else begin
                     ram_we    = 1'b1;
                     ram_waddr = '0;
                     ram_wdata = req_data.color_in;
                     count_in  = CW'(1);
                     res_in    = '{index_out: '0, color_out: req_data.color_in,
                                   status: pca_pkg::STAT_ADDED};
                  end
               end
            end
         end

         pca_pkg::ST_SCAN: begin
            if (cmp_valid_ff) begin
               if (near_ff) begin
                  if ({1'b0, chan_max} < best_dist_ff) begin
                     best_idx_in   = cmp_idx_ff;
                     best_dist_in  = {1'b0, chan_max};
                     best_color_in = ram_rdata;
                  end
                  if (chan_max == '0 || cmp_last) begin
                     scan_done = 1'b1;
                     res_in    = '{index_out: 8'(best_idx_in), color_out: best_color_in,
                                   status: pca_pkg::STAT_EXISTING};
                  end
               end else if (ram_rdata == color_ff) begin
                  scan_done = 1'b1;
                  res_in    = '{index_out: 8'(cmp_idx_ff), color_out: ram_rdata,
                                status: pca_pkg::STAT_EXISTING};
               end else if (cmp_last) begin
                  scan_done = 1'b1;
                  if (func_ff == pca_pkg::FUNC_EXACT) begin
                     res_in = '{index_out: '0, color_out: '0,
                                status: pca_pkg::STAT_NOMATCH};
                  end else if (count_ff == CW'(PALETTE_SIZE)) begin
                     res_in = '{index_out: '0, color_out: '0,
                                status: pca_pkg::STAT_FULL};
                  end else begin
                     // append at the fill level
                     ram_we   = 1'b1;
                     count_in = count_ff + CW'(1);
                     res_in   = '{index_out: 8'(count_ff), color_out: color_ff,
                                  status: pca_pkg::STAT_ADDED};
                  end
               end
            end
            if (!scan_done && issue_ff < count_ff) begin
               ram_re       = 1'b1;
               cmp_valid_in = 1'b1;
               cmp_idx_in   = AW'(issue_ff);
               issue_in     = issue_ff + CW'(1);
            end
         end

         pca_pkg::ST_READ: begin
            // entries at or above the fill level read as zero
            res_in = '{index_out: 8'(cmp_idx_ff),
                       color_out: (CW'(cmp_idx_ff) < count_ff) ? ram_rdata : 24'h0,
                       status: pca_pkg::STAT_EXISTING};
         end

         pca_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end

         default: begin
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pca_pkg::ST_IDLE: begin
            if (req_xfer) begin
               if (req_data.func == pca_pkg::FUNC_READ) begin
                  state_in = pca_pkg::ST_READ;
               end else if (count_ff == '0) begin
                  state_in = pca_pkg::ST_DONE;
               end else begin
                  state_in = pca_pkg::ST_SCAN;
               end
            end
         end
         pca_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = pca_pkg::ST_DONE;
            end
         end
         pca_pkg::ST_READ: begin
            state_in = pca_pkg::ST_DONE;
         end
         pca_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = pca_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pca_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pca_pkg::ST_IDLE;
         count_ff     <= '0;
         mode_ff      <= 1'b0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_wdata;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      color_ff      <= color_in;
      near_ff       <= near_in;
      issue_ff      <= issue_in;
      cmp_idx_ff    <= cmp_idx_in;
      best_idx_ff   <= best_idx_in;
      best_dist_ff  <= best_dist_in;
      best_color_ff <= best_color_in;
      res_ff        <= res_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // palette storage
   pca_ram #(
      .WIDTH (24),
      .DEPTH (PALETTE_SIZE)
   ) u_palette_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // checks
`include "palette_color_allocator_top_assert.svh"

   `PCA_ASSERT_NOW(a_append_room, clock, reset, ram_we, count_ff < CW'(PALETTE_SIZE), "palette append beyond capacity")
   `PCA_ASSERT_NEXT(a_append_count, clock, reset, ram_we, count_ff == $past(count_ff) + CW'(1), "entry count did not follow append")
   `PCA_ASSERT_NEXT(a_accept_busy, clock, reset, req_xfer, state_ff != pca_pkg::ST_IDLE, "sequencer idle after accepted transfer")
   `PCA_ASSERT_NOW(a_write_idle, clock, reset, ram_we && ram_re, 1'b0, "ram read and write in the same cycle")

endmodule

// ----- bench/palette_color_allocator_checker.sv -----
// checker for the palette color allocator: predicts every result and compares
module palette_color_allocator_checker #(
   parameter int unsigned PALETTE_SIZE = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  pca_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  pca_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic             csr_wdata,
   output int               fail_count,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import pca_pkg::*;

   logic [COLOR_W-1:0] shadow_palette [PALETTE_SIZE];
   int unsigned        shadow_count;
   logic               shadow_fixed_mode;
   rsp_type            palette_rsp_q [$];
   int                 mismatches = 0;

   function automatic int unsigned chan_gap(logic [7:0] a, logic [7:0] b);
      return (a > b) ? int'(a - b) : int'(b - a);
   endfunction

   // largest per-channel absolute difference
   function automatic int unsigned color_distance(logic [23:0] x, logic [23:0] y);
      int unsigned d;
      int unsigned e;
      d = chan_gap(x[23:16], y[23:16]);
      e = chan_gap(x[15:8], y[15:8]);
      if (e > d) d = e;
      e = chan_gap(x[7:0], y[7:0]);
      if (e > d) d = e;
      return d;
   endfunction

   // first entry wins a tie, scan ends at distance zero
   function automatic int unsigned nearest_entry(logic [23:0] color);
      int unsigned best = 0;
      int unsigned best_dist = 'hffff;
      int unsigned d;
      for (int unsigned i = 0; i < shadow_count && i < PALETTE_SIZE; i++) begin
         d = color_distance(color, shadow_palette[i]);
         if (d < best_dist) begin
            best = i;
            best_dist = d;
            if (d == 0) break;
         end
      end
      return best;
   endfunction

   function automatic bit exact_entry(input logic [23:0] color, output int unsigned where);
      where = 0;
      for (int unsigned i = 0; i < shadow_count && i < PALETTE_SIZE; i++) begin
         if (shadow_palette[i] == color) begin
            where = i;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // works out the result of one request and updates the shadow palette
   function automatic rsp_type predict_palette_rsp(req_type r);
      rsp_type     p;
      int unsigned idx;
      idx = 0;
      p.color_out = '0;
      p.status = STAT_EXISTING;
      if (r.func == FUNC_READ) begin
         idx = (r.index_in < PALETTE_SIZE) ? r.index_in : 0;
         p.color_out = shadow_palette[idx];
      end else if (r.func == FUNC_NEAREST || (r.func == FUNC_ALLOC && shadow_fixed_mode)) begin
         idx = nearest_entry(r.color_in);
         p.color_out = shadow_palette[idx];
      end else if (r.func == FUNC_EXACT) begin
         if (exact_entry(r.color_in, idx)) begin
            p.color_out = shadow_palette[idx];
         end else begin
            idx = 0;
            p.status = STAT_NOMATCH;
         end
      end else begin
         if (exact_entry(r.color_in, idx)) begin
            p.color_out = shadow_palette[idx];
         end else if (shadow_count >= PALETTE_SIZE) begin
            idx = 0;
            p.status = STAT_FULL;
         end else begin
            idx = shadow_count;
            shadow_palette[idx] = r.color_in;
            shadow_count++;
            p.color_out = r.color_in;
            p.status = STAT_ADDED;
         end
      end
      p.index_out = idx[INDEX_W-1:0];
      return p;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int unsigned i = 0; i < PALETTE_SIZE; i++) shadow_palette[i] = '0;
         shadow_count = 0;
         shadow_fixed_mode = 1'b0;
         palette_rsp_q.delete();
      end else begin
         if (csr_valid && csr_ready) shadow_fixed_mode = csr_wdata;
         if (rsp_valid && !rsp_stall) begin
            if (palette_rsp_q.size() == 0) begin
               $error("result transfer with nothing expected: index_out %0d color_out %06h",
                      rsp_data.index_out, rsp_data.color_out);
               mismatches++;
            end else begin
               want = palette_rsp_q.pop_front();
               if (rsp_data.index_out !== want.index_out) begin
                  $error("index_out mismatch: expected %0d, actual %0d",
                         want.index_out, rsp_data.index_out);
                  mismatches++;
               end
               if (rsp_data.color_out !== want.color_out) begin
                  $error("color_out mismatch: expected %06h, actual %06h",
                         want.color_out, rsp_data.color_out);
                  mismatches++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         want.status, rsp_data.status);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) palette_rsp_q.push_back(predict_palette_rsp(req_data));
      end
      fail_count <= mismatches;
      pending <= palette_rsp_q.size();
   end

endmodule

// ----- bench/palette_color_allocator_top_test.sv -----
// testbench top for the palette color allocator: stimulus and verdict
module palette_color_allocator_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import pca_pkg::*;

   localparam int unsigned PALETTE_SIZE     = 256;
   // budget covers a full-table scan per item plus random idle gaps on both sides
   localparam int unsigned CYCLE_LIMIT      = 3_000_000;
   localparam int unsigned LONG_HOLD_AFTER  = 60;
   localparam int unsigned LONG_HOLD_CYCLES = 1000;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b1;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic    csr_wdata = 1'b0;

   int fail_count;
   int pending;

   int unsigned    cycle_count = 0;
   int unsigned    items_sent = 0;
   int unsigned    rsp_seen = 0;
   bit             sender_quiet = 1'b0;
   bit             receiver_quiet = 1'b0;
   // colors offered for allocation, reused to hit existing entries
   logic [23:0]    alloc_colors [$];

   palette_color_allocator_top #(
      .PALETTE_SIZE(PALETTE_SIZE)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   palette_color_allocator_checker #(
      .PALETTE_SIZE(PALETTE_SIZE)
   ) checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog: a hung handshake or a lost result ends here
   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // result side: random stall per transfer, quiet stretches, and one long
   // hold-off so the block fills its result register and stalls requests
   initial begin
      int unsigned hold;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_seen == LONG_HOLD_AFTER) hold = LONG_HOLD_CYCLES;
         else hold = receiver_quiet ? 0 : $urandom_range(0, 9);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         rsp_seen++;
         if (rsp_seen % 48 == 0) receiver_quiet = ($urandom_range(0, 3) == 0);
      end
   end

   // one request transfer; valid stays high into the next item when there is no gap
   task automatic send_req(func_type f, logic [23:0] c, logic [7:0] ix);
      int unsigned gap;
      gap = sender_quiet ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= '{func: f, color_in: c, index_in: ix};
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (items_sent % 40 == 0) sender_quiet = ($urandom_range(0, 3) == 0);
      if (f == FUNC_ALLOC) alloc_colors.push_back(c);
   endtask

   // mode changes only with no request in flight
   task automatic drain;
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_fixed_mode(logic v);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // shift each channel by a few steps, clamped, to land near an entry
   function automatic logic [23:0] nudge_color(logic [23:0] c);
      logic [23:0] r;
      int          v;
      for (int ch = 0; ch < 3; ch++) begin
         v = int'(c[ch*8 +: 8]) + int'($urandom_range(0, 6)) - 3;
         if (v < 0) v = 0;
         if (v > 255) v = 255;
         r[ch*8 +: 8] = v[7:0];
      end
      return r;
   endfunction

   function automatic logic [23:0] pick_color(int unsigned fresh_pct);
      logic [23:0] c;
      c = 24'($urandom_range(0, 24'hffffff));
      if ($urandom_range(0, 99) < fresh_pct || alloc_colors.size() == 0) return c;
      case ($urandom_range(0, 2))
         0: begin
            case ($urandom_range(0, 4))
               0: c = 24'h000000;
               1: c = 24'hffffff;
               2: c = 24'hff0000;
               3: c = 24'h00ff00;
               default: c = 24'h0000ff;
            endcase
         end
         1: c = alloc_colors[$urandom_range(0, alloc_colors.size() - 1)];
         default: c = nudge_color(alloc_colors[$urandom_range(0, alloc_colors.size() - 1)]);
      endcase
      return c;
   endfunction

   task automatic send_random_item(int unsigned alloc_pct, int unsigned fresh_pct);
      func_type f;
      if ($urandom_range(0, 99) < alloc_pct) begin
         f = FUNC_ALLOC;
      end else begin
         case ($urandom_range(0, 2))
            0: f = FUNC_NEAREST;
            1: f = FUNC_EXACT;
            default: f = FUNC_READ;
         endcase
      end
      send_req(f, pick_color(fresh_pct), 8'($urandom_range(0, 255)));
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // fixed mode on an empty palette: allocate and nearest fall back to entry 0
      write_fixed_mode(1'b1);
      send_req(FUNC_ALLOC, 24'h123456, 8'h00);
      send_req(FUNC_NEAREST, 24'hffffff, 8'hff);
      // exact on an empty palette misses even though entry 0 reads as zero
      send_req(FUNC_EXACT, 24'h000000, 8'h00);
      send_req(FUNC_READ, 24'hffffff, 8'h00);
      send_req(FUNC_READ, 24'h000000, 8'hff);
      drain();

      write_fixed_mode(1'b0);
      send_req(FUNC_ALLOC, 24'h000000, 8'h00);
      send_req(FUNC_ALLOC, 24'hffffff, 8'hff);
      send_req(FUNC_ALLOC, 24'h000000, 8'h00);   // already present
      send_req(FUNC_ALLOC, 24'h808080, 8'h55);
      send_req(FUNC_EXACT, 24'hffffff, 8'h00);
      send_req(FUNC_EXACT, 24'h010101, 8'h00);   // no exact match
      send_req(FUNC_NEAREST, 24'h404040, 8'h00); // tie between entries 0 and 2
      send_req(FUNC_NEAREST, 24'hfefefe, 8'h00);
      send_req(FUNC_NEAREST, 24'h808080, 8'h00); // zero distance
      send_req(FUNC_READ, 24'h000000, 8'h01);
      send_req(FUNC_READ, 24'h000000, 8'h02);
      send_req(FUNC_READ, 24'h000000, 8'h03);    // never written, reads zero
      send_req(FUNC_READ, 24'hffffff, 8'hff);
      send_req(FUNC_NEAREST, 24'hff0000, 8'haa);
      send_req(FUNC_ALLOC, 24'hff0000, 8'hff);
      send_req(FUNC_ALLOC, 24'h00ff00, 8'h00);
      send_req(FUNC_ALLOC, 24'h0000ff, 8'h00);
      send_req(FUNC_NEAREST, 24'h7f00ff, 8'h00);

      // mostly fresh allocations until the table is full and refuses more
      repeat (380) send_random_item(85, 85);
      drain();

      // fixed mode against a full palette
      write_fixed_mode(1'b1);
      repeat (250) send_random_item(50, 40);
      drain();

      // back to adding mode: new colors now report a full table
      write_fixed_mode(1'b0);
      repeat (420) send_random_item(50, 40);

      // all requests out: wait for every result, then let the block settle
      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule
